// File: rtl/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply core.
// Holds the beat structs, controller state enum and command/status bundles.
// No dependencies.
package mvm_pkg;

  localparam int MAX_COLUMNS   = 256;
  localparam int ELEMENT_BITS  = 16;
  localparam int ACC_BITS      = 40;
  localparam int ROW_BITS      = 16;
  localparam int INDEX_BITS    = 8;
  localparam int PROD_BITS     = 2 * ELEMENT_BITS;
  localparam int COL_BITS      = $clog2(MAX_COLUMNS);
  localparam int COUNT_BITS    = $clog2(MAX_COLUMNS + 1);
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [COUNT_BITS-1:0] COLUMNS_RESET = COUNT_BITS'(MAX_COLUMNS);

  // Register index, taken from the word address
  localparam logic REG_COLUMNS_IN_USE = 1'b0;

  // Input beat kinds
  localparam logic KIND_VECTOR = 1'b0;
  localparam logic KIND_MATRIX = 1'b1;

  typedef struct packed {
    logic                           kind;
    logic        [INDEX_BITS-1:0]   element_index;
    logic signed [ELEMENT_BITS-1:0] element_value;
    logic                           final_row;
  } in_beat_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] row_sum;
    logic        [ROW_BITS-1:0] row_number;
    logic                       last;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;   // latch the accepted beat
    logic ram_we;    // write vector entry
    logic mul_en;    // register the product
    logic acc_en;    // add product into the row sum
    logic col_adv;   // step to the next column
    logic emit;      // load result register, restart the row
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_kind;
    logic row_done;
  } dp_status_t;

endpackage

// File: rtl/mvm_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

// File: rtl/mvm_ctrl.sv
// Controller state machine for the matrix-vector multiply core.
// Depends on mvm_pkg; drives datapath commands and the result valid flag.
module mvm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mvm_pkg::dp_status_t status,
  output mvm_pkg::ctrl_cmd_t  cmd
);

  mvm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            in_accept;

  assign in_stall  = (state_r != mvm_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvm_pkg::S_IDLE: begin
        if (in_valid && status.in_kind == mvm_pkg::KIND_MATRIX) begin
          state_nxt = mvm_pkg::S_MUL;
        end
      end
      mvm_pkg::S_MUL: begin
        state_nxt = mvm_pkg::S_ACC;
      end
      mvm_pkg::S_ACC: begin
        state_nxt = status.row_done ? mvm_pkg::S_EMIT : mvm_pkg::S_IDLE;
      end
      mvm_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = mvm_pkg::S_IDLE;
        end
      end
      default: state_nxt = mvm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      mvm_pkg::S_IDLE: begin
        cmd.capture = in_accept;
        cmd.ram_we  = in_accept && (status.in_kind == mvm_pkg::KIND_VECTOR);
      end
      mvm_pkg::S_MUL: begin
        cmd.mul_en = 1'b1;
      end
      mvm_pkg::S_ACC: begin
        cmd.acc_en  = 1'b1;
        cmd.col_adv = !status.row_done;
      end
      mvm_pkg::S_EMIT: begin
        cmd.emit = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is loaded only into a free or draining output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a held beat");

  // Multiply stage runs only right after a matrix beat was taken
  a_mul_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mvm_pkg::S_MUL) |->
      $past(in_valid && !in_stall && status.in_kind == mvm_pkg::KIND_MATRIX))
    else $error("multiply without a matrix beat");

  // An emitted result shows as valid on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");

endmodule

// File: rtl/mvm_datapath.sv
// Datapath for the matrix-vector multiply core: vector store, multiplier,
// row accumulator, counters and the result register. Depends on mvm_pkg, mvm_ram.
module mvm_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mvm_pkg::in_beat_t                 in_data,
  input  logic [mvm_pkg::COUNT_BITS-1:0]    eff_columns,
  input  mvm_pkg::ctrl_cmd_t                cmd,
  output mvm_pkg::dp_status_t               status,
  output mvm_pkg::out_beat_t                out_data
);

  logic signed [mvm_pkg::ELEMENT_BITS-1:0] val_r;
  logic                                    fin_r;
  logic signed [mvm_pkg::PROD_BITS-1:0]    prod_r;
  logic signed [mvm_pkg::ACC_BITS-1:0]     acc_r, acc_nxt;
  logic        [mvm_pkg::COL_BITS-1:0]     col_r, col_nxt;
  logic        [mvm_pkg::ROW_BITS-1:0]     row_r, row_nxt;
  mvm_pkg::out_beat_t                      out_r;
  logic        [mvm_pkg::COL_BITS-1:0]     ram_addr;
  logic        [mvm_pkg::ELEMENT_BITS-1:0] ram_rdata;

  assign ram_addr = cmd.ram_we ? in_data.element_index[mvm_pkg::COL_BITS-1:0] : col_r;

  mvm_ram #(
    .WIDTH (mvm_pkg::ELEMENT_BITS),
    .DEPTH (mvm_pkg::MAX_COLUMNS)
  ) u_vec_ram (
    .clk     (clk),
    .we      (cmd.ram_we),
    .addr    (ram_addr),
    .wdata   (in_data.element_value),
    .rdata_r (ram_rdata)
  );

  assign status.in_kind  = in_data.kind;
  assign status.row_done = ({1'b0, col_r} + mvm_pkg::COUNT_BITS'(1)) >= eff_columns;

  always_comb begin
    acc_nxt = acc_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.acc_en) begin
      acc_nxt = acc_r + {{(mvm_pkg::ACC_BITS - mvm_pkg::PROD_BITS){prod_r[mvm_pkg::PROD_BITS-1]}},
                         prod_r};
    end
    if (cmd.col_adv) begin
      col_nxt = col_r + mvm_pkg::COL_BITS'(1);
    end
    if (cmd.emit) begin
      acc_nxt = '0;
      col_nxt = '0;
      row_nxt = fin_r ? '0 : row_r + mvm_pkg::ROW_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r <= in_data.element_value;
      fin_r <= in_data.final_row;
    end
    if (cmd.mul_en) begin
      prod_r <= val_r * $signed(ram_rdata);
    end
    if (cmd.emit) begin
      out_r.row_sum    <= acc_r;
      out_r.row_number <= row_r;
      out_r.last       <= fin_r;
    end
  end

  assign out_data = out_r;

  // Row restart leaves a clean accumulator and column count
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (acc_r == '0 && col_r == '0))
    else $error("row state not cleared after result");

  // A final-row result restarts row numbering
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && fin_r) |=> (row_r == '0))
    else $error("row counter not restarted after last row");

endmodule

// File: rtl/matrix_vector_multiply_core.sv
// Top level of the dense matrix-vector multiply core: APB register, controller
// and datapath. Depends on mvm_pkg, mvm_ctrl, mvm_datapath (and mvm_ram below it).
//
//   channel   direction  handshake              payload
//   in_       sink       in_valid / in_stall    mvm_pkg::in_beat_t
//   out_      source     out_valid / out_stall  mvm_pkg::out_beat_t
//   apb       slave      psel/penable/pready    columns_in_use at byte address 0
//
// A vector-load beat is written to the vector store when accepted. A matrix beat
// goes through vector RAM read, registered 16x16 multiply and 40-bit accumulate,
// with the input stalled until it is done. The beat that completes a row then
// waits while a previous result is still held by out_stall, and loads the result
// register. Reset (synchronous, rst_n low) clears the accumulator, column
// and row counters and sets columns_in_use to 256; the vector store is not
// cleared, so load every entry before it is used.
module matrix_vector_multiply_core (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  mvm_pkg::in_beat_t                   in_data,

  output logic                                out_valid,
  input  logic                                out_stall,
  output mvm_pkg::out_beat_t                  out_data,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mvm_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [mvm_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [mvm_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready
);

  logic [mvm_pkg::COUNT_BITS-1:0] columns_r, columns_nxt;
  logic [mvm_pkg::COUNT_BITS-1:0] eff_columns;
  logic                           reg_sel;
  mvm_pkg::ctrl_cmd_t             cmd;
  mvm_pkg::dp_status_t            status;

  // Word address picks the register; the two low byte bits are ignored
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    columns_nxt = columns_r;
    if (psel && penable && pwrite && pready && reg_sel == mvm_pkg::REG_COLUMNS_IN_USE) begin
      columns_nxt = pwdata[mvm_pkg::COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= mvm_pkg::COLUMNS_RESET;
    end else begin
      columns_r <= columns_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == mvm_pkg::REG_COLUMNS_IN_USE) begin
      prdata = mvm_pkg::CFG_DATA_BITS'(columns_r);
    end
  end

  // Clamp the column count: zero acts as one, anything above the store depth
  // acts as the full depth
  always_comb begin
    eff_columns = columns_r;
    if (columns_r == '0) begin
      eff_columns = mvm_pkg::COUNT_BITS'(1);
    end else if (columns_r > mvm_pkg::COLUMNS_RESET) begin
      eff_columns = mvm_pkg::COLUMNS_RESET;
    end
  end

  mvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mvm_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .eff_columns (eff_columns),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data)
  );

endmodule

// File: verif/mvm_checker.sv
`timescale 1ns / 1ps
// Checker for matrix_vector_multiply_core: watches the beat channels and the APB port,
// predicts each row result and compares it field by field. Depends on mvm_pkg.
module mvm_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  mvm_pkg::in_beat_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  mvm_pkg::out_beat_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [mvm_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [mvm_pkg::CFG_DATA_BITS-1:0]   pwdata,
  input  logic [mvm_pkg::CFG_DATA_BITS-1:0]   prdata,
  output int                                  mismatches,
  output int                                  rows_waiting,
  output int                                  rows_checked
);

  localparam logic [mvm_pkg::CFG_ADDR_BITS-1:0] COLUMNS_ADDR =
    mvm_pkg::CFG_ADDR_BITS'(4 * mvm_pkg::REG_COLUMNS_IN_USE);

  logic signed [mvm_pkg::ELEMENT_BITS-1:0] x_store [mvm_pkg::MAX_COLUMNS];
  logic        [mvm_pkg::ACC_BITS-1:0]     acc_run;
  logic        [mvm_pkg::COL_BITS-1:0]     col_pos;
  logic        [mvm_pkg::ROW_BITS-1:0]     row_idx;
  logic        [mvm_pkg::COUNT_BITS-1:0]   cols_cfg;
  mvm_pkg::out_beat_t                      expected_rows [$];

  function automatic int clamped_columns(input logic [mvm_pkg::COUNT_BITS-1:0] c);
    if (c == 0) return 1;
    if (c > mvm_pkg::MAX_COLUMNS) return mvm_pkg::MAX_COLUMNS;
    return int'(c);
  endfunction

  // Store a vector beat, or add a matrix beat to the row; queue the row sum at close.
  task automatic accumulate_beat(input mvm_pkg::in_beat_t b);
    logic signed [mvm_pkg::PROD_BITS-1:0] prod;
    mvm_pkg::out_beat_t                   row;
    if (b.kind == mvm_pkg::KIND_VECTOR) begin
      x_store[b.element_index] = b.element_value;
    end else begin
      prod = $signed(b.element_value) * $signed(x_store[col_pos]);
      acc_run = acc_run + {{(mvm_pkg::ACC_BITS - mvm_pkg::PROD_BITS){prod[mvm_pkg::PROD_BITS-1]}},
                           prod};
      if (int'(col_pos) + 1 < clamped_columns(cols_cfg)) begin
        col_pos = col_pos + 1'b1;
      end else begin
        row.row_sum    = acc_run;
        row.row_number = row_idx;
        row.last       = b.final_row;
        expected_rows.push_back(row);
        acc_run = '0;
        col_pos = '0;
        row_idx = b.final_row ? '0 : row_idx + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    mvm_pkg::out_beat_t want;
    if (!rst_n) begin
      acc_run = '0;
      col_pos = '0;
      row_idx = '0;
      cols_cfg = mvm_pkg::COLUMNS_RESET;
      expected_rows.delete();
      mismatches = 0;
      rows_checked = 0;
    end else begin
      // Results first: a row sum never leaves in the cycle its last beat enters.
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected result beat: row_sum %0d row_number %0d last %0b",
                 out_data.row_sum, out_data.row_number, out_data.last);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          rows_checked++;
          if (out_data.row_sum !== want.row_sum) begin
            $error("row_sum: expected %0d, got %0d", want.row_sum, out_data.row_sum);
            mismatches++;
          end
          if (out_data.row_number !== want.row_number) begin
            $error("row_number: expected %0d, got %0d", want.row_number, out_data.row_number);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            mismatches++;
          end
        end
      end
      if (psel && penable && pready && paddr == COLUMNS_ADDR) begin
        if (pwrite) begin
          cols_cfg = pwdata[mvm_pkg::COUNT_BITS-1:0];
        end else if (prdata !== mvm_pkg::CFG_DATA_BITS'(cols_cfg)) begin
          $error("columns_in_use: expected %0d, got %0d", cols_cfg, prdata);
          mismatches++;
        end
      end
      if (in_valid && !in_stall) accumulate_beat(in_data);
    end
    rows_waiting = expected_rows.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for matrix_vector_multiply_core: clock, reset, stimulus and verdict.
// Depends on mvm_pkg, the core RTL and mvm_checker, which does all prediction.
module tb;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat and no APB access
  localparam int SETTLE_CYCLES  = 8;     // covers the multiply path plus emit
  localparam int PHASES         = 12;
  localparam logic [mvm_pkg::CFG_ADDR_BITS-1:0] COLUMNS_ADDR =
    mvm_pkg::CFG_ADDR_BITS'(4 * mvm_pkg::REG_COLUMNS_IN_USE);

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  mvm_pkg::in_beat_t                 in_data;
  logic                              out_valid;
  logic                              out_stall;
  mvm_pkg::out_beat_t                out_data;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [mvm_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [mvm_pkg::CFG_DATA_BITS-1:0] pwdata;
  logic [mvm_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                              pready;

  int mismatches;
  int rows_waiting;
  int rows_checked;
  int loads_sent;
  int elems_sent;
  int settings_used;
  int quiet_cycles;
  bit steady;  // high: neither side idles or stalls

  // Column settings of the random part: reset value, clamp above, zero acting as one,
  // and a spread of small and odd sizes. Most phases keep rows short.
  int phase_cols  [PHASES] = '{256, 511, 1, 0, 2, 3, 7, 16, 33, 64, 255, 300};
  int phase_items [PHASES] = '{150, 150, 100, 60, 80, 80, 80, 80, 100, 100, 120, 120};

  matrix_vector_multiply_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  mvm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .mismatches   (mismatches),
    .rows_waiting (rows_waiting),
    .rows_checked (rows_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result side: stall in about a third of the cycles, never during a steady stretch.
  always @(negedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 35);
  end

  // Watchdog: restart on any beat or APB access, give up after a long quiet spell.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle cycles before the next input beat; geometric, continuing with 35 percent odds.
  function automatic int idle_gap();
    int n;
    n = 0;
    if (steady) return 0;
    while ($urandom_range(0, 99) < 35) n++;
    return n;
  endfunction

  // Extremes show up often so the products hit both signs at full scale.
  function automatic logic signed [mvm_pkg::ELEMENT_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(mvm_pkg::ELEMENT_BITS - 1){1'b0}}};
      1:       return {1'b0, {(mvm_pkg::ELEMENT_BITS - 1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return mvm_pkg::ELEMENT_BITS'($urandom);
    endcase
  endfunction

  // Drive one beat from a falling edge and hold it until accepted. Valid stays high
  // across back-to-back beats; it drops only for an idle gap or in wait_idle.
  task automatic send_beat(input mvm_pkg::in_beat_t b);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [mvm_pkg::INDEX_BITS-1:0] idx,
                           input logic signed [mvm_pkg::ELEMENT_BITS-1:0] val);
    mvm_pkg::in_beat_t b;
    b.kind          = mvm_pkg::KIND_VECTOR;
    b.element_index = idx;
    b.element_value = val;
    b.final_row     = 1'($urandom_range(0, 1));  // ignored on loads
    send_beat(b);
    loads_sent++;
  endtask

  task automatic send_elem(input logic signed [mvm_pkg::ELEMENT_BITS-1:0] val,
                           input logic fin);
    mvm_pkg::in_beat_t b;
    b.kind          = mvm_pkg::KIND_MATRIX;
    b.element_index = mvm_pkg::INDEX_BITS'($urandom);  // ignored on matrix beats
    b.element_value = val;
    b.final_row     = fin;
    send_beat(b);
    elems_sent++;
  endtask

  // Drop valid, wait for every queued row sum, then let in-flight beats settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (rows_waiting != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One APB transfer: setup, access, then a spare idle step so transfers never share a step.
  task automatic cfg_access(input logic write_op,
                            input logic [mvm_pkg::CFG_DATA_BITS-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_op;
    paddr   <= COLUMNS_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write columns_in_use while idle, then read it back for the checker.
  task automatic set_columns(input int cols);
    wait_idle();
    cfg_access(1'b1, mvm_pkg::CFG_DATA_BITS'(cols));
    cfg_access(1'b0, '0);
    settings_used++;
  endtask

  initial begin
    int order [mvm_pkg::MAX_COLUMNS];
    int pick;
    int swap;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    steady        = 1'b0;
    loads_sent    = 0;
    elems_sent    = 0;
    settings_used = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset value of columns_in_use.
    cfg_access(1'b0, '0);

    // Two-column rows at full scale; index 0 and 255 cover both ends of the store.
    set_columns(2);
    send_load(8'd0, -16'sd32768);
    send_load(8'd1, 16'sd32767);
    send_load(8'd255, -16'sd1);
    // Final mark on a non-closing element must be ignored.
    send_elem(-16'sd32768, 1'b1);
    send_elem(16'sd32767, 1'b0);
    // Load into the store mid-row; the closing element reads the new entry and
    // its final mark flags the row last and restarts numbering.
    send_elem(16'sd32767, 1'b0);
    send_load(8'd1, -16'sd32768);
    send_elem(-16'sd32768, 1'b1);
    send_elem(16'sd0, 1'b0);
    send_elem(-16'sd1, 1'b0);

    // Lower the column count with a row half done: the next element closes it.
    send_elem(16'sd1, 1'b0);
    set_columns(1);
    send_elem(16'sd5, 1'b0);

    // Zero columns behaves as one: every element closes a row.
    set_columns(0);
    send_elem(-16'sd32768, 1'b0);
    send_elem(16'sd32767, 1'b1);
    send_elem(-16'sd1, 1'b0);

    // Random phases. The first fills the whole vector store in shuffled order, so
    // every later read hits a written entry.
    for (int p = 0; p < PHASES; p++) begin
      set_columns(phase_cols[p]);
      if (p == 0) begin
        for (int i = 0; i < mvm_pkg::MAX_COLUMNS; i++) order[i] = i;
        for (int i = mvm_pkg::MAX_COLUMNS - 1; i > 0; i--) begin
          pick        = $urandom_range(0, i);
          swap        = order[i];
          order[i]    = order[pick];
          order[pick] = swap;
        end
        for (int i = 0; i < mvm_pkg::MAX_COLUMNS; i++) begin
          send_load(mvm_pkg::INDEX_BITS'(order[i]), rand_value());
        end
      end
      // Single-column phase runs flat out on both sides.
      steady = (p == 2);
      for (int i = 0; i < phase_items[p]; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_load(mvm_pkg::INDEX_BITS'($urandom_range(0, mvm_pkg::MAX_COLUMNS - 1)),
                    rand_value());
        end else begin
          send_elem(rand_value(), $urandom_range(0, 5) == 0);
        end
      end
      steady = 1'b0;
    end

    wait_idle();
    $display("Sent %0d vector loads and %0d matrix elements; checked %0d row sums",
             loads_sent, elems_sent, rows_checked);
    $display("Ran %0d column settings, from zero and one up to 256 and the clamped 511",
             settings_used);
    if (mismatches == 0 && rows_waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
